// File: sv/fdc_pkg.sv
package fdc_pkg;

  localparam int CYLINDERS    = 80;
  localparam int SIDES        = 2;
  localparam int SECTORS      = 9;
  localparam int SECTOR_BYTES = 512;
  localparam int FORMAT_BYTES = 8000;
  localparam int PHASE_TICKS  = 5;

  localparam int DISK_SECTORS = CYLINDERS * SIDES * SECTORS;
  localparam int DISK_BYTES   = DISK_SECTORS * SECTOR_BYTES;
  localparam int ADDR_W       = $clog2(DISK_BYTES);
  localparam int OFF_W        = $clog2(SECTOR_BYTES) + 1;
  localparam int IDX_W        = 16;

  localparam logic [7:0] MARK_BYTE = 8'hf5;
  localparam logic [7:0] ID_BYTE   = 8'hfe;
  localparam logic [7:0] DATA_BYTE = 8'hfb;
  localparam logic [7:0] MOTOR_ON  = 8'h80;

  localparam logic [3:0] CMD_RESTORE = 4'h0;
  localparam logic [3:0] CMD_SEEK    = 4'h1;
  localparam logic [3:0] CMD_READ    = 4'h8;
  localparam logic [3:0] CMD_FORCE   = 4'hd;
  localparam logic [2:0] CMD_RD_GRP  = 3'b100;
  localparam logic [2:0] CMD_WR_GRP  = 3'b101;
  localparam logic [2:0] CMD_FMT_GRP = 3'b111;
  localparam logic [1:0] CMD_XFER    = 2'b10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SIDE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_CMD    = 2'd0,
    REG_TRACK  = 2'd1,
    REG_SECTOR = 2'd2,
    REG_DATA   = 2'd3
  } reg_e;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } sec_loc_t;

  function automatic sec_loc_t sector_start(logic [7:0] trk, logic sd, logic [7:0] sec);
    sec_loc_t          r;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       full;
    idx  = (IDX_W'(trk) * IDX_W'(SIDES) + IDX_W'(sd)) * IDX_W'(SECTORS)
           + IDX_W'(sec) - IDX_W'(1);
    full = 32'(idx) * 32'(SECTOR_BYTES);
    r.ok   = (sec != 8'd0) && (idx < IDX_W'(DISK_SECTORS));
    r.addr = r.ok ? full[ADDR_W-1:0] : '0;
    return r;
  endfunction

endpackage

// File: sv/fdc_ram.sv
module fdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/floppy_disk_controller.sv
// Floppy disk controller with command/status, track, sector and data
// registers over a byte store holding the whole disk.
// Input channel: drive op_i, reg_sel_i, wdata_i, side_i and raise start;
// the beat is taken at a rising edge where start is high and busy is low.
// Each beat is a tick, a register read, a register write or a side select.
// Result channel: every beat gives one result (rdata_o, error_o), shown
// for one cycle with done_o high, after the beat passes stage_q and done_o.
// The receiver cannot stall; results are never held.
// No new beat is taken before the last is through. Step one reads the disk
// store at the current byte pointer (registered read); step two updates all
// registers, writes the store and registers the result; busy is high then.
// Reset: registers clear, then the disk store is cleared one byte a cycle,
// all DISK_BYTES (737280) bytes, with busy high throughout.
module floppy_disk_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [1:0] reg_sel_i,
  input  logic [7:0] wdata_i,
  input  logic       side_i,
  output logic       done_o,
  output logic [7:0] rdata_o,
  output logic       error_o
);
  import fdc_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PREP, PH_EXEC} phase_e;
  typedef enum logic [1:0] {PARSE_HUNT, PARSE_ID, PARSE_BODY} fmt_e;

  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              stage_q, stage_d;
  op_e               op_q;
  reg_e              sel_q;
  logic [7:0]        val_q;
  logic              side_in_q;

  logic [7:0]        track_q, track_d, sector_q, sector_d, data_q, data_d;
  logic              side_q, side_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        cmd_q, cmd_d;
  logic              cmd_valid_q, cmd_valid_d;
  logic [2:0]        tick_q, tick_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              bad_q, bad_d;
  logic              tz_q, tz_d;
  fmt_e              fmt_q, fmt_d;
  logic [1:0]        marks_q, marks_d;
  logic [OFF_W-1:0]  foff_q, foff_d;
  logic [12:0]       frem_q, frem_d;
  logic [7:0]        fsec_q, fsec_d;
  logic [ADDR_W-1:0] ftgt_q, ftgt_d;
  logic              fok_q, fok_d;
  logic              done_d, err_d;
  logic [7:0]        rdata_d;

  logic              accept;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wbyte;
  logic [7:0]        mem_rdata;
  logic              op_we;
  logic [ADDR_W-1:0] op_waddr;

  logic [ADDR_W:0]   adv_sum;
  logic [ADDR_W-1:0] adv_addr;
  logic              adv_wrap, adv_end;
  logic [OFF_W-1:0]  foff_inc;
  sec_loc_t          cmd_loc, fmt_loc;
  logic              in_exec, is_rd, is_wr, is_fmt;

  assign busy   = clr_q | stage_q;
  assign accept = start & ~busy;

  assign adv_sum  = {1'b0, addr_q} + (ADDR_W+1)'(1);
  assign adv_wrap = adv_sum >= (ADDR_W+1)'(DISK_BYTES);
  assign adv_addr = adv_wrap ? '0 : adv_sum[ADDR_W-1:0];
  assign adv_end  = (adv_addr % ADDR_W'(SECTOR_BYTES)) == '0;
  assign foff_inc = foff_q + OFF_W'(1);

  assign cmd_loc = sector_start(track_q, side_q, sector_q);
  assign fmt_loc = sector_start(track_q, side_q, fsec_q);

  assign in_exec = (phase_q == PH_EXEC) && cmd_valid_q;
  assign is_rd   = in_exec && (cmd_q[7:5] == CMD_RD_GRP);
  assign is_wr   = in_exec && (cmd_q[7:5] == CMD_WR_GRP);
  assign is_fmt  = in_exec && (cmd_q[7:5] == CMD_FMT_GRP);

  always_comb begin
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    stage_d     = accept;
    track_d     = track_q;
    sector_d    = sector_q;
    data_d      = data_q;
    side_d      = side_q;
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    tick_d      = tick_q;
    addr_d      = addr_q;
    bad_d       = bad_q;
    tz_d        = tz_q;
    fmt_d       = fmt_q;
    marks_d     = marks_q;
    foff_d      = foff_q;
    frem_d      = frem_q;
    fsec_d      = fsec_q;
    ftgt_d      = ftgt_q;
    fok_d       = fok_q;
    done_d      = stage_q;
    err_d       = 1'b0;
    rdata_d     = 8'd0;
    op_we       = 1'b0;
    op_waddr    = addr_q;

    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DISK_BYTES - 1)) begin
        clr_d = 1'b0;
      end
    end

    if (stage_q) begin
      case (op_q)
        OP_TICK: begin
          if (phase_q == PH_PREP) begin
            if (tick_q <= 3'd1) begin
              phase_d = PH_EXEC;
              tick_d  = 3'(PHASE_TICKS);
            end else begin
              tick_d = tick_q - 3'd1;
            end
          end else if (phase_q == PH_EXEC) begin
            if (tick_q <= 3'd1) begin
              phase_d = PH_IDLE;
              tick_d  = 3'd0;
            end else begin
              tick_d = tick_q - 3'd1;
            end
          end
        end
        OP_READ: begin
          case (sel_q)
            REG_CMD: begin
              rdata_d = MOTOR_ON;
              if (phase_q == PH_EXEC) begin
                rdata_d[0] = 1'b1;
                rdata_d[1] = cmd_valid_q && cmd_q[7];
              end
              rdata_d[2] = tz_q && (!cmd_valid_q || !cmd_q[7]);
            end
            REG_TRACK:  rdata_d = track_q;
            REG_SECTOR: rdata_d = sector_q;
            default: begin
              if (!is_rd) begin
                err_d   = 1'b1;
                rdata_d = data_q;
              end else begin
                rdata_d = bad_q ? 8'd0 : mem_rdata;
                err_d   = bad_q;
                addr_d  = adv_addr;
                if (adv_wrap) bad_d = 1'b1;
                if (adv_end && cmd_q[7:4] == CMD_READ) begin
                  phase_d = PH_IDLE;
                  tick_d  = 3'd0;
                end else begin
                  tick_d = 3'(PHASE_TICKS);
                end
              end
            end
          endcase
        end
        OP_WRITE: begin
          case (sel_q)
            REG_CMD: begin
              cmd_d       = val_q;
              cmd_valid_d = 1'b1;
              phase_d     = PH_PREP;
              tick_d      = 3'(PHASE_TICKS);
              if (val_q[7:4] == CMD_RESTORE) begin
                track_d = 8'd0;
                tz_d    = 1'b1;
              end else if (val_q[7:4] == CMD_SEEK) begin
                track_d = data_q;
                tz_d    = (data_q == 8'd0);
              end else if (val_q[7:6] == CMD_XFER) begin
                bad_d  = !cmd_loc.ok;
                addr_d = cmd_loc.addr;
                tz_d   = 1'b0;
              end else if (val_q[7:4] == CMD_FORCE) begin
                phase_d = PH_IDLE;
                tick_d  = 3'd0;
                tz_d    = 1'b0;
              end else if (val_q[7:5] == CMD_FMT_GRP) begin
                tz_d    = 1'b0;
                fmt_d   = PARSE_HUNT;
                marks_d = 2'd0;
                foff_d  = '0;
                frem_d  = 13'(FORMAT_BYTES);
                fsec_d  = 8'd0;
                ftgt_d  = '0;
                fok_d   = 1'b0;
              end
            end
            REG_TRACK:  track_d = val_q;
            REG_SECTOR: sector_d = val_q;
            default: begin
              if (is_wr) begin
                err_d  = bad_q;
                op_we  = !bad_q;
                addr_d = adv_addr;
                if (adv_wrap) bad_d = 1'b1;
                if (adv_end) begin
                  phase_d = PH_IDLE;
                  tick_d  = 3'd0;
                end else begin
                  tick_d = 3'(PHASE_TICKS);
                end
              end else if (is_fmt) begin
                if (frem_q != 13'd0) frem_d = frem_q - 13'd1;
                case (fmt_q)
                  PARSE_HUNT: begin
                    if (val_q == MARK_BYTE) begin
                      if (marks_q != 2'd3) marks_d = marks_q + 2'd1;
                    end else begin
                      if (marks_q == 2'd3 && val_q == ID_BYTE) begin
                        fmt_d  = PARSE_ID;
                        foff_d = '0;
                      end else if (marks_q == 2'd3 && val_q == DATA_BYTE) begin
                        fmt_d  = PARSE_BODY;
                        foff_d = '0;
                        if (fsec_q >= 8'd1 && fsec_q <= 8'(SECTORS)) begin
                          fok_d  = fmt_loc.ok;
                          ftgt_d = fmt_loc.addr;
                          err_d  = !fmt_loc.ok;
                        end else begin
                          ftgt_d = '0;
                          fok_d  = 1'b0;
                        end
                      end
                      marks_d = 2'd0;
                    end
                  end
                  PARSE_ID: begin
                    if (foff_q == OFF_W'(2)) fsec_d = val_q;
                    foff_d = foff_inc;
                    if (foff_inc >= OFF_W'(4)) fmt_d = PARSE_HUNT;
                  end
                  default: begin
                    op_waddr = ftgt_q + ADDR_W'(foff_q);
                    op_we    = fok_q && (foff_q < OFF_W'(SECTOR_BYTES));
                    foff_d   = foff_inc;
                    if (foff_inc >= OFF_W'(SECTOR_BYTES)) begin
                      fmt_d  = PARSE_HUNT;
                      foff_d = '0;
                      fok_d  = 1'b0;
                    end
                  end
                endcase
                if (frem_d == 13'd0) begin
                  phase_d = PH_IDLE;
                  tick_d  = 3'd0;
                end else begin
                  tick_d = 3'(PHASE_TICKS);
                end
              end else begin
                data_d = val_q;
              end
            end
          endcase
        end
        default: side_d = side_in_q;
      endcase
    end
  end

  assign we    = clr_q | op_we;
  assign waddr = clr_q ? clr_addr_q : op_waddr;
  assign wbyte = clr_q ? 8'd0 : val_q;

  fdc_ram #(
    .WIDTH(8),
    .DEPTH(DISK_BYTES)
  ) u_disk (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wbyte),
    .re_i   (accept),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      stage_q     <= 1'b0;
      op_q        <= OP_TICK;
      sel_q       <= REG_CMD;
      val_q       <= 8'd0;
      side_in_q   <= 1'b0;
      track_q     <= 8'd0;
      sector_q    <= 8'd0;
      data_q      <= 8'd0;
      side_q      <= 1'b0;
      phase_q     <= PH_IDLE;
      cmd_q       <= 8'd0;
      cmd_valid_q <= 1'b0;
      tick_q      <= 3'd0;
      addr_q      <= '0;
      bad_q       <= 1'b0;
      tz_q        <= 1'b0;
      fmt_q       <= PARSE_HUNT;
      marks_q     <= 2'd0;
      foff_q      <= '0;
      frem_q      <= 13'd0;
      fsec_q      <= 8'd0;
      ftgt_q      <= '0;
      fok_q       <= 1'b0;
      done_o      <= 1'b0;
      rdata_o     <= 8'd0;
      error_o     <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      stage_q     <= stage_d;
      if (accept) begin
        op_q      <= op_e'(op_i);
        sel_q     <= reg_e'(reg_sel_i);
        val_q     <= wdata_i;
        side_in_q <= side_i;
      end
      track_q     <= track_d;
      sector_q    <= sector_d;
      data_q      <= data_d;
      side_q      <= side_d;
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      cmd_valid_q <= cmd_valid_d;
      tick_q      <= tick_d;
      addr_q      <= addr_d;
      bad_q       <= bad_d;
      tz_q        <= tz_d;
      fmt_q       <= fmt_d;
      marks_q     <= marks_d;
      foff_q      <= foff_d;
      frem_q      <= frem_d;
      fsec_q      <= fsec_d;
      ftgt_q      <= ftgt_d;
      fok_q       <= fok_d;
      done_o      <= done_d;
      rdata_o     <= rdata_d;
      error_o     <= err_d;
    end
  end

endmodule
